FILE: design/swept_box_collision_response_core_macros.svh
// Assertion macros shared by the collision response checker.
// Depends on nothing; included by the checker file only.
`ifndef SWEPT_BOX_COLLISION_RESPONSE_CORE_MACROS_SVH
`define SWEPT_BOX_COLLISION_RESPONSE_CORE_MACROS_SVH

// Property checked on every rising edge, ignored while reset is held.
`define SBCR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SBCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/sbcr_pkg.sv
// Types, codes and helper functions for the swept box collision response core.
// Depends on nothing; imported by the core.
`timescale 1ns / 1ps

package sbcr_pkg;

    // Per-axis slab outcome.
    typedef enum logic [1:0] {
        AX_MISS  = 2'd0,
        AX_OPEN  = 2'd1,
        AX_BOUND = 2'd2
    } axis_code_t;

    // Normal component codes.
    localparam logic signed [1:0] N_ZERO = 2'sb00;
    localparam logic signed [1:0] N_POS  = 2'sb01;
    localparam logic signed [1:0] N_NEG  = 2'sb11;

    // Number of quotient bits of the entry time.
    localparam int unsigned TQ_BITS = 16;

    // Slab result for one axis: entry and exit numerators and the divisor.
    typedef struct packed {
        axis_code_t         code;
        logic signed [19:0] nn;
        logic signed [19:0] fn;
        logic [38:0]        dd;
    } axis_t;

    // Values carried along the pipeline with each item.
    typedef struct packed {
        logic               hit;
        logic signed [1:0]  nrx;
        logic signed [1:0]  nry;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [16:0] ox;
        logic signed [16:0] oy;
        logic signed [39:0] dx;
        logic signed [39:0] dy;
    } ctx_t;

    // Clamp to the signed 24 bit range.
    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        logic signed [23:0] r;
        if (v > 40'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -40'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

FILE: design/swept_box_collision_response_core.sv
// Swept box collision response core: a streaming pipeline of 22 register stages.
// One item enters in every cycle while the pipeline is not stalled; the entry time
// is formed by the 16 stage restoring divider, one quotient bit per stage.
// Each stage holds its own valid bit and only waits when the stage after it is
// full and stalled, so bubbles close up and the input keeps taking transfers
// while a finished result waits at the output.
// Depends on sbcr_pkg.
`timescale 1ns / 1ps

module swept_box_collision_response_core
    import sbcr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mover_x, mover_y, mover_w, mover_h, vel_x, vel_y, step_time,
    // wall_x, wall_y, wall_w, wall_h; zero padding in [191:188]
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_vel_x, new_vel_y, contact_time, normal_x, normal_y,
    // contact_x, contact_y; zero padding in [119:116]
    output logic [119:0] m_tdata,
    // hit
    output logic [0:0]   m_tuser
);

    localparam int NSTG = 22;
    localparam int DIV0 = 5;

    logic [NSTG:1] vld_reg;
    logic [NSTG:1] rdy;

    // Ready chain: a stage loads when it is empty or its successor loads.
    always_comb begin
        rdy[NSTG] = !vld_reg[NSTG] || m_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k + 1];
        end
    end

    assign s_tready = rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    // Input field unpacking.
    logic signed [15:0] in_mx, in_my, in_wx, in_wy;
    logic [14:0]        in_mw, in_mh, in_ww, in_wh;
    logic signed [23:0] in_vx, in_vy;
    logic [15:0]        in_st;

    assign in_mx = s_tdata[15:0];
    assign in_my = s_tdata[31:16];
    assign in_mw = s_tdata[46:32];
    assign in_mh = s_tdata[61:47];
    assign in_vx = s_tdata[85:62];
    assign in_vy = s_tdata[109:86];
    assign in_st = s_tdata[125:110];
    assign in_wx = s_tdata[141:126];
    assign in_wy = s_tdata[157:142];
    assign in_ww = s_tdata[172:158];
    assign in_wh = s_tdata[187:173];

    // Stage 1: centre, expanded box edges and ray direction.
    logic signed [16:0] s1_ox_reg, s1_oy_reg, s1_lox_reg, s1_loy_reg;
    logic signed [17:0] s1_hix_reg, s1_hiy_reg;
    logic signed [39:0] s1_dx_reg, s1_dy_reg;
    logic signed [23:0] s1_vx_reg, s1_vy_reg;
    logic signed [16:0] s1_lox_next, s1_loy_next;

    assign s1_lox_next = 17'(in_wx) - $signed({3'b000, in_mw[14:1]});
    assign s1_loy_next = 17'(in_wy) - $signed({3'b000, in_mh[14:1]});

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s1_ox_reg  <= 17'(in_mx) + $signed({3'b000, in_mw[14:1]});
            s1_oy_reg  <= 17'(in_my) + $signed({3'b000, in_mh[14:1]});
            s1_lox_reg <= s1_lox_next;
            s1_loy_reg <= s1_loy_next;
            s1_hix_reg <= 18'(s1_lox_next) + $signed({2'b00, 16'(in_ww) + 16'(in_mw)});
            s1_hiy_reg <= 18'(s1_loy_next) + $signed({2'b00, 16'(in_wh) + 16'(in_mh)});
            s1_dx_reg  <= in_vx * $signed({1'b0, in_st});
            s1_dy_reg  <= in_vy * $signed({1'b0, in_st});
            s1_vx_reg  <= in_vx;
            s1_vy_reg  <= in_vy;
        end
    end

    // Stage 2: slab classification per axis.
    function automatic axis_t slab_f(input logic signed [16:0] lo,
                                     input logic signed [17:0] hi,
                                     input logic signed [16:0] o,
                                     input logic signed [39:0] d);
        axis_t a;
        a.nn = '0;
        a.fn = '0;
        a.dd = '0;
        if (d == 40'sd0) begin
            a.code = (o > lo && 18'(o) < hi) ? AX_OPEN : AX_MISS;
        end else if (!d[39]) begin
            a.code = AX_BOUND;
            a.nn   = 20'(lo) - 20'(o);
            a.fn   = 20'(hi) - 20'(o);
            a.dd   = d[38:0];
        end else begin
            a.code = AX_BOUND;
            a.nn   = 20'(o) - 20'(hi);
            a.fn   = 20'(o) - 20'(lo);
            a.dd   = 39'(-d);
        end
        return a;
    endfunction

    axis_t s2_ax_reg, s2_ay_reg;
    ctx_t  s2_ctx_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s2_ax_reg      <= slab_f(s1_lox_reg, s1_hix_reg, s1_ox_reg, s1_dx_reg);
            s2_ay_reg      <= slab_f(s1_loy_reg, s1_hiy_reg, s1_oy_reg, s1_dy_reg);
            s2_ctx_reg.hit <= 1'b0;
            s2_ctx_reg.nrx <= N_ZERO;
            s2_ctx_reg.nry <= N_ZERO;
            s2_ctx_reg.vx  <= s1_vx_reg;
            s2_ctx_reg.vy  <= s1_vy_reg;
            s2_ctx_reg.ox  <= s1_ox_reg;
            s2_ctx_reg.oy  <= s1_oy_reg;
            s2_ctx_reg.dx  <= s1_dx_reg;
            s2_ctx_reg.dy  <= s1_dy_reg;
        end
    end

    // Stage 3: cross products for the interval overlap and tie tests.
    axis_t              s3_ax_reg, s3_ay_reg;
    ctx_t               s3_ctx_reg;
    logic signed [59:0] s3_nxdy_reg, s3_fydx_reg, s3_nydx_reg, s3_fxdy_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            s3_ax_reg   <= s2_ax_reg;
            s3_ay_reg   <= s2_ay_reg;
            s3_ctx_reg  <= s2_ctx_reg;
            s3_nxdy_reg <= s2_ax_reg.nn * $signed({1'b0, s2_ay_reg.dd});
            s3_fydx_reg <= s2_ay_reg.fn * $signed({1'b0, s2_ax_reg.dd});
            s3_nydx_reg <= s2_ay_reg.nn * $signed({1'b0, s2_ax_reg.dd});
            s3_fxdy_reg <= s2_ax_reg.fn * $signed({1'b0, s2_ay_reg.dd});
        end
    end

    // Stage 4: hit decision, entry axis and normal, divider set-up.
    ctx_t               s4_ctx_next;
    logic signed [19:0] s4_tn;
    logic [38:0]        s4_td;
    logic               s4_hit;
    logic               s4_late;

    always_comb begin
        s4_ctx_next = s3_ctx_reg;
        s4_hit      = 1'b1;
        s4_tn       = s3_ax_reg.nn;
        s4_td       = s3_ax_reg.dd;
        if ((s3_ctx_reg.vx == 24'sd0 && s3_ctx_reg.vy == 24'sd0) ||
            s3_ax_reg.code == AX_MISS || s3_ay_reg.code == AX_MISS ||
            (s3_ax_reg.code == AX_OPEN && s3_ay_reg.code == AX_OPEN)) begin
            s4_hit = 1'b0;
        end else if (s3_ax_reg.code == AX_BOUND && s3_ay_reg.code == AX_BOUND) begin
            if (s3_nxdy_reg > s3_fydx_reg || s3_nydx_reg > s3_fxdy_reg ||
                s3_ax_reg.fn[19] || s3_ay_reg.fn[19]) begin
                s4_hit = 1'b0;
            end
            if (s3_nxdy_reg > s3_nydx_reg) begin
                s4_ctx_next.nrx = s3_ctx_reg.dx[39] ? N_POS : N_NEG;
            end else if (s3_nxdy_reg < s3_nydx_reg) begin
                s4_tn           = s3_ay_reg.nn;
                s4_td           = s3_ay_reg.dd;
                s4_ctx_next.nry = s3_ctx_reg.dy[39] ? N_POS : N_NEG;
            end
        end else if (s3_ax_reg.code == AX_BOUND) begin
            if (s3_ax_reg.fn[19]) begin
                s4_hit = 1'b0;
            end
            s4_ctx_next.nrx = s3_ctx_reg.dx[39] ? N_POS : N_NEG;
        end else begin
            s4_tn = s3_ay_reg.nn;
            s4_td = s3_ay_reg.dd;
            if (s3_ay_reg.fn[19]) begin
                s4_hit = 1'b0;
            end
            s4_ctx_next.nry = s3_ctx_reg.dy[39] ? N_POS : N_NEG;
        end
        // Entry time must lie in [0,1).
        s4_late = s4_tn[19] || ({4'b0000, s4_tn[18:0], 16'h0000} >= s4_td);
        s4_ctx_next.hit = s4_hit && !s4_late;
    end

    ctx_t        s4_ctx_reg;
    logic [39:0] s4_rem_reg;
    logic [38:0] s4_td_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            s4_ctx_reg <= s4_ctx_next;
            s4_rem_reg <= s4_ctx_next.hit ? {21'd0, s4_tn[18:0]} : 40'd0;
            s4_td_reg  <= s4_ctx_next.hit ? s4_td : 39'd1;
        end
    end

    // Stages 5 to 20: restoring divider, one quotient bit per stage.
    ctx_t              dv_ctx_reg [TQ_BITS];
    logic [39:0]       dv_rem_reg [TQ_BITS];
    logic [38:0]       dv_td_reg  [TQ_BITS];
    logic [TQ_BITS-1:0] dv_q_reg  [TQ_BITS];

    for (genvar i = 0; i < TQ_BITS; i++) begin : g_div
        ctx_t               ctx_in;
        logic [39:0]        rem_in;
        logic [38:0]        td_in;
        logic [TQ_BITS-1:0] q_in;
        logic [40:0]        dbl;
        logic [40:0]        dif;

        if (i == 0) begin : g_first
            assign ctx_in = s4_ctx_reg;
            assign rem_in = s4_rem_reg;
            assign td_in  = s4_td_reg;
            assign q_in   = '0;
        end else begin : g_rest
            assign ctx_in = dv_ctx_reg[i - 1];
            assign rem_in = dv_rem_reg[i - 1];
            assign td_in  = dv_td_reg[i - 1];
            assign q_in   = dv_q_reg[i - 1];
        end

        assign dbl = {rem_in, 1'b0};
        assign dif = dbl - {2'b00, td_in};

        always_ff @(posedge aclk) begin
            if (rdy[DIV0 + i]) begin
                dv_ctx_reg[i] <= ctx_in;
                dv_td_reg[i]  <= td_in;
                if (!dif[40]) begin
                    dv_rem_reg[i] <= dif[39:0];
                    dv_q_reg[i]   <= {q_in[TQ_BITS-2:0], 1'b1};
                end else begin
                    dv_rem_reg[i] <= dbl[39:0];
                    dv_q_reg[i]   <= {q_in[TQ_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Stage 21: velocity scaling and contact offset products.
    ctx_t               s21_ctx_reg;
    logic [15:0]        s21_tq_reg;
    logic [40:0]        s21_pvx_reg, s21_pvy_reg;
    logic signed [56:0] s21_pcx_reg, s21_pcy_reg;
    logic [15:0]        s21_tq_next;
    logic [16:0]        s21_fac;
    logic [23:0]        s21_avx, s21_avy;

    assign s21_tq_next = dv_q_reg[TQ_BITS - 1];
    assign s21_fac     = 17'h10000 - {1'b0, s21_tq_next};
    assign s21_avx     = dv_ctx_reg[TQ_BITS - 1].vx[23] ?
                         24'(-dv_ctx_reg[TQ_BITS - 1].vx) : dv_ctx_reg[TQ_BITS - 1].vx;
    assign s21_avy     = dv_ctx_reg[TQ_BITS - 1].vy[23] ?
                         24'(-dv_ctx_reg[TQ_BITS - 1].vy) : dv_ctx_reg[TQ_BITS - 1].vy;

    always_ff @(posedge aclk) begin
        if (rdy[21]) begin
            s21_ctx_reg <= dv_ctx_reg[TQ_BITS - 1];
            s21_tq_reg  <= s21_tq_next;
            s21_pvx_reg <= s21_avx * s21_fac;
            s21_pvy_reg <= s21_avy * s21_fac;
            s21_pcx_reg <= $signed({1'b0, s21_tq_next}) * dv_ctx_reg[TQ_BITS - 1].dx;
            s21_pcy_reg <= $signed({1'b0, s21_tq_next}) * dv_ctx_reg[TQ_BITS - 1].dy;
        end
    end

    // Stage 22: resolved velocity, contact point and output register.
    function automatic logic signed [23:0] resolve_f(input logic signed [23:0] v,
                                                     input logic signed [1:0]  n,
                                                     input logic [40:0]        p);
        logic signed [39:0] r;
        logic signed [23:0] o;
        r = $signed({15'd0, p[40:16]});
        case (n)
            N_POS:   o = sat24(40'(v) + r);
            N_NEG:   o = sat24(40'(v) - r);
            default: o = v;
        endcase
        return o;
    endfunction

    function automatic logic signed [23:0] contact_f(input logic signed [16:0] o,
                                                     input logic signed [56:0] p);
        logic signed [39:0] s;
        s = 40'($signed({o, 8'h00})) + 40'(p >>> 24);
        return sat24(s);
    endfunction

    logic [119:0] m_tdata_reg, m_tdata_next;
    logic         m_hit_reg;

    always_comb begin
        m_tdata_next = '0;
        if (s21_ctx_reg.hit) begin
            m_tdata_next[23:0]   = resolve_f(s21_ctx_reg.vx, s21_ctx_reg.nrx, s21_pvx_reg);
            m_tdata_next[47:24]  = resolve_f(s21_ctx_reg.vy, s21_ctx_reg.nry, s21_pvy_reg);
            m_tdata_next[63:48]  = s21_tq_reg;
            m_tdata_next[65:64]  = s21_ctx_reg.nrx;
            m_tdata_next[67:66]  = s21_ctx_reg.nry;
            m_tdata_next[91:68]  = contact_f(s21_ctx_reg.ox, s21_pcx_reg);
            m_tdata_next[115:92] = contact_f(s21_ctx_reg.oy, s21_pcy_reg);
        end else begin
            m_tdata_next[23:0]  = s21_ctx_reg.vx;
            m_tdata_next[47:24] = s21_ctx_reg.vy;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NSTG]) begin
            m_tdata_reg <= m_tdata_next;
            m_hit_reg   <= s21_ctx_reg.hit;
        end
    end

    assign m_tvalid   = vld_reg[NSTG];
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_hit_reg;

endmodule

FILE: design/sbcr_checker.sv
// Port level checks for the swept box collision response core, with its bind.
// Depends on swept_box_collision_response_core_macros.svh.
`timescale 1ns / 1ps
`include "swept_box_collision_response_core_macros.svh"

module sbcr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // Views of the result channel used by the checks below.
    logic         m_hold;
    logic         m_miss;
    logic [120:0] m_bits;
    logic [67:0]  contact_bits;
    logic [1:0]   nrm_x, nrm_y;
    logic         nrm_ok;

    assign m_hold       = m_tvalid && !m_tready;
    assign m_miss       = m_tvalid && !m_tuser[0];
    assign m_bits       = {m_tuser, m_tdata};
    assign contact_bits = m_tdata[115:48];
    assign nrm_x        = m_tdata[65:64];
    assign nrm_y        = m_tdata[67:66];
    assign nrm_ok       = nrm_x != 2'b10 && nrm_y != 2'b10 &&
                          (nrm_x == 2'b00 || nrm_y == 2'b00);

    // No result is offered in the cycle after reset.
    `SBCR_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result transfer holds its value.
    `SBCR_ASSERT(a_hold, aclk, aresetn, m_hold |=> m_tvalid && $stable(m_bits), "held result changed")

    // A miss carries no contact time, normal or contact point.
    `SBCR_ASSERT(a_miss_zero, aclk, aresetn, m_miss |-> contact_bits == '0, "contact data on a miss")

    // A normal never points along both axes and never takes the unused code.
    `SBCR_ASSERT(a_normal, aclk, aresetn, m_tvalid |-> nrm_ok, "bad normal")

endmodule

bind swept_box_collision_response_core sbcr_checker u_sbcr_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the swept box collision response core.
// Drives collision queries over the input stream and checks every result
// against a behavioural predictor of its own; depends on the core and sbcr_pkg.
`timescale 1ns / 1ps

module tb;
    import sbcr_pkg::*;

    // One collision query, fields at the widths of the block.
    typedef struct {
        logic signed [15:0] mx, my;
        logic [14:0]        mw, mh;
        logic signed [23:0] vx, vy;
        logic [15:0]        st;
        logic signed [15:0] wx, wy;
        logic [14:0]        ww, wh;
    } query_t;

    // One collision response.
    typedef struct {
        logic               hit;
        logic signed [23:0] nvx, nvy;
        logic [15:0]        ct;
        logic signed [1:0]  nx, ny;
        logic signed [23:0] cx, cy;
    } response_t;

    localparam int CYCLE_LIMIT = 400000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // mover_x, mover_y, mover_w, mover_h, vel_x, vel_y, step_time,
    // wall_x, wall_y, wall_w, wall_h, zero padding
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // new_vel_x, new_vel_y, contact_time, normal_x, normal_y,
    // contact_x, contact_y, zero padding
    logic [119:0] m_tdata;
    // hit
    logic [0:0]   m_tuser;

    response_t pending_responses[$];
    int        fail_count = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_cycles = 0;
    int        cycle_count = 0;

    swept_box_collision_response_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit, in case the block stops producing results.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Saturate to the signed 24 bit range.
    function automatic longint clamp24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Slab of one axis: 0 miss, 1 unbounded, 2 bounded with numerators and divisor.
    function automatic int axis_slab(input longint lo, input longint size,
                                     input longint o, input longint d,
                                     output longint near_n, output longint far_n,
                                     output longint div);
        longint hi;
        hi = lo + size;
        near_n = 0;
        far_n = 0;
        div = 1;
        if (d == 0) return (o > lo && o < hi) ? 1 : 0;
        if (d > 0) begin
            near_n = lo - o;
            far_n = hi - o;
            div = d;
        end else begin
            near_n = o - hi;
            far_n = o - lo;
            div = -d;
        end
        return 2;
    endfunction

    // Works out the response that the block should give for one query.
    function automatic response_t predict_response(input query_t q);
        response_t r;
        longint mw, mh, ox, oy, vx, vy, dx, dy;
        longint nx, fx, ddx, ny, fy, ddy, tn, td, tq, c, nrx, nry, adj;
        int     ax, ay;
        bit     hit;
        mw = q.mw;
        mh = q.mh;
        vx = q.vx;
        vy = q.vy;
        ox = longint'(q.mx) + mw / 2;
        oy = longint'(q.my) + mh / 2;
        dx = vx * longint'(q.st);
        dy = vy * longint'(q.st);
        ax = axis_slab(longint'(q.wx) - mw / 2, longint'(q.ww) + mw, ox, dx, nx, fx, ddx);
        ay = axis_slab(longint'(q.wy) - mh / 2, longint'(q.wh) + mh, oy, dy, ny, fy, ddy);
        hit = 1'b1;
        tn = 0;
        td = 1;
        nrx = 0;
        nry = 0;
        if ((vx == 0 && vy == 0) || ax == 0 || ay == 0 || (ax == 1 && ay == 1)) begin
            hit = 1'b0;
        end else if (ax == 2 && ay == 2) begin
            c = nx * ddy - ny * ddx;
            if (nx * ddy > fy * ddx || ny * ddx > fx * ddy) hit = 1'b0;
            if (fx < 0 || fy < 0) hit = 1'b0;
            if (c > 0) begin
                tn = nx; td = ddx; nrx = dx < 0 ? 1 : -1;
            end else if (c < 0) begin
                tn = ny; td = ddy; nry = dy < 0 ? 1 : -1;
            end else begin
                tn = nx; td = ddx;
            end
        end else if (ax == 2) begin
            if (fx < 0) hit = 1'b0;
            tn = nx; td = ddx; nrx = dx < 0 ? 1 : -1;
        end else begin
            if (fy < 0) hit = 1'b0;
            tn = ny; td = ddy; nry = dy < 0 ? 1 : -1;
        end
        if (hit && (tn < 0 || tn * 65536 >= td)) hit = 1'b0;

        r.hit = hit;
        r.nvx = q.vx;
        r.nvy = q.vy;
        r.ct = '0;
        r.nx = N_ZERO;
        r.ny = N_ZERO;
        r.cx = '0;
        r.cy = '0;
        if (hit) begin
            tq = (tn * 65536) / td;
            // Cancel the normal component of velocity over the rest of the step.
            if (nrx != 0) begin
                adj = ((vx < 0 ? -vx : vx) * (65536 - tq)) >>> 16;
                r.nvx = 24'(clamp24(vx + nrx * adj));
            end
            if (nry != 0) begin
                adj = ((vy < 0 ? -vy : vy) * (65536 - tq)) >>> 16;
                r.nvy = 24'(clamp24(vy + nry * adj));
            end
            r.ct = tq[15:0];
            r.nx = nrx[1:0];
            r.ny = nry[1:0];
            r.cx = 24'(clamp24(ox * 256 + ((tq * dx) >>> 24)));
            r.cy = 24'(clamp24(oy * 256 + ((tq * dy) >>> 24)));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, field, got, want);
        fail_count++;
    endtask

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: each transfer against the oldest expected response.
    always @(posedge aclk) begin
        response_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_responses.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle_count);
                fail_count++;
            end else begin
                want = pending_responses.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", m_tuser[0], want.hit);
                if ($signed(m_tdata[23:0]) !== want.nvx)
                    report_mismatch("new_vel_x", $signed(m_tdata[23:0]), want.nvx);
                if ($signed(m_tdata[47:24]) !== want.nvy)
                    report_mismatch("new_vel_y", $signed(m_tdata[47:24]), want.nvy);
                if (m_tdata[63:48] !== want.ct)
                    report_mismatch("contact_time", m_tdata[63:48], want.ct);
                if ($signed(m_tdata[65:64]) !== want.nx)
                    report_mismatch("normal_x", $signed(m_tdata[65:64]), want.nx);
                if ($signed(m_tdata[67:66]) !== want.ny)
                    report_mismatch("normal_y", $signed(m_tdata[67:66]), want.ny);
                if ($signed(m_tdata[91:68]) !== want.cx)
                    report_mismatch("contact_x", $signed(m_tdata[91:68]), want.cx);
                if ($signed(m_tdata[115:92]) !== want.cy)
                    report_mismatch("contact_y", $signed(m_tdata[115:92]), want.cy);
            end
        end
    end

    // Offers one query and waits for its transfer; records the expected response.
    task automatic send_query(input query_t q);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, q.wh, q.ww, q.wy, q.wx, q.st, q.vy, q.vx,
                    q.mh, q.mw, q.my, q.mx};
        do @(posedge aclk); while (!s_tready);
        pending_responses.push_back(predict_response(q));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
    endtask

    function automatic query_t make_query(input int mx, my, mw, mh, vx, vy, st,
                                          input int wx, wy, ww, wh);
        query_t q;
        q.mx = 16'(mx); q.my = 16'(my); q.mw = 15'(mw); q.mh = 15'(mh);
        q.vx = 24'(vx); q.vy = 24'(vy); q.st = 16'(st);
        q.wx = 16'(wx); q.wy = 16'(wy); q.ww = 15'(ww); q.wh = 15'(wh);
        return q;
    endfunction

    // Fully random query over the whole field ranges.
    function automatic query_t noise_query();
        query_t q;
        q.mx = 16'($urandom); q.my = 16'($urandom);
        q.mw = 15'($urandom); q.mh = 15'($urandom);
        q.vx = 24'($urandom); q.vy = 24'($urandom); q.st = 16'($urandom);
        q.wx = 16'($urandom); q.wy = 16'($urandom);
        q.ww = 15'($urandom); q.wh = 15'($urandom);
        return q;
    endfunction

    // Mover placed near the wall and heading roughly towards it, so hits are common.
    function automatic query_t approach_query();
        query_t q;
        int     span;
        span = $urandom_range(1) ? 64 : 2000;
        q.wx = 16'($urandom_range(2 * span) - span);
        q.wy = 16'($urandom_range(2 * span) - span);
        q.ww = 15'($urandom_range(span));
        q.wh = 15'($urandom_range(span));
        q.mw = 15'($urandom_range(span / 2));
        q.mh = 15'($urandom_range(span / 2));
        q.mx = 16'(int'(q.wx) + $urandom_range(4 * span) - 2 * span);
        q.my = 16'(int'(q.wy) + $urandom_range(4 * span) - 2 * span);
        q.vx = 24'((int'(q.wx) - int'(q.mx)) * ($urandom_range(512) + 1)
                   + $urandom_range(2048) - 1024);
        q.vy = 24'((int'(q.wy) - int'(q.my)) * ($urandom_range(512) + 1)
                   + $urandom_range(2048) - 1024);
        if ($urandom_range(7) == 0) q.vy = '0;
        q.st = $urandom_range(1) ? 16'h0100 : 16'($urandom_range(1024));
        return q;
    endfunction

    // Field extremes and the special cases of the slab test.
    task automatic test_directed();
        // No motion, and zero step.
        send_query(make_query(0, 0, 4, 4, 0, 0, 256, 10, 0, 4, 4));
        send_query(make_query(0, 0, 4, 4, 2560, 0, 0, 10, 0, 4, 4));
        // Straight hit along x in both directions, and along y.
        send_query(make_query(0, 0, 4, 4, 2560, 0, 256, 10, 0, 4, 4));
        send_query(make_query(20, 0, 4, 4, -2560, 0, 256, 10, 0, 4, 4));
        send_query(make_query(0, 0, 4, 4, 0, 2560, 256, 0, 10, 4, 4));
        send_query(make_query(0, 20, 4, 4, 0, -2560, 256, 0, 10, 4, 4));
        // Zero direction with the centre on the slab edge and outside it.
        send_query(make_query(0, 4, 4, 4, 2560, 0, 256, 10, 0, 4, 4));
        send_query(make_query(0, 40, 4, 4, 2560, 0, 256, 10, 0, 4, 4));
        // Tie of entry times on a diagonal approach.
        send_query(make_query(0, 0, 2, 2, 2560, 2560, 256, 10, 10, 4, 4));
        // Starting inside the box, and a slower approach that enters the box later in the step.
        send_query(make_query(10, 0, 4, 4, 2560, 0, 256, 10, 0, 4, 4));
        send_query(make_query(0, 0, 4, 4, 2048, 0, 256, 10, 0, 4, 4));
        // Field extremes.
        send_query(make_query(-32768, -32768, 32767, 32767, 8388607, 8388607, 65535,
                              32767, 32767, 32767, 32767));
        send_query(make_query(32767, 32767, 0, 0, -8388608, -8388608, 65535,
                              -32768, -32768, 0, 0));
        send_query(make_query(-32768, 0, 0, 0, 8388607, 0, 65535,
                              32767, -1, 32767, 2));
        send_query(make_query(32767, 0, 32767, 1, -8388608, 1, 1,
                              -32768, 0, 32767, 32767));
        send_query(make_query(0, 0, 0, 0, -1, 0, 65535, -1, -1, 0, 2));
        wait_for_results();
    endtask

    // Random queries, mostly aimed, under the current idling and stall settings.
    task automatic test_random(input int count);
        repeat (count) begin
            if ($urandom_range(99) < 75) send_query(approach_query());
            else send_query(noise_query());
        end
        wait_for_results();
    endtask

    // Long receiver hold-off while the sender keeps offering, so the pipe fills.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 200;
        repeat (60) send_query(approach_query());
        wait_for_results();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        idle_pct = 0;  stall_pct = 0;  test_random(110);
        idle_pct = 65; stall_pct = 0;  test_random(110);
        idle_pct = 0;  stall_pct = 65; test_random(110);
        idle_pct = 27; stall_pct = 27; test_random(110);
        test_backpressure();

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_responses.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/sbcr_pkg.sv
design/swept_box_collision_response_core.sv
design/sbcr_checker.sv
tb/tb.sv
